// ----- hdl/updi_pkg.sv -----
// Shared types and constants for the UPDI half-duplex UART line engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package updi_pkg;

  localparam int unsigned CountWidth = 24;
  localparam int unsigned BitTicksWidth = 16;
  localparam int unsigned BrkWidth = 24;
  localparam int unsigned CfgDataWidth = 24;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CountWidth-1:0] CntMax = {CountWidth{1'b1}};

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_SEND   = 3'd1,
    OP_RECV   = 3'd2,
    OP_BREAK  = 3'd3,
    OP_DBREAK = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_BIT_TICKS   = 2'd0,
    CFG_BREAK_LOW   = 2'd1,
    CFG_BREAK_PAUSE = 2'd2,
    CFG_RX_TIMEOUT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_TX_START     = 4'd1,
    PH_TX_DATA      = 4'd2,
    PH_TX_PARITY    = 4'd3,
    PH_TX_STOP      = 4'd4,
    PH_RX_WAIT      = 4'd5,
    PH_RX_HALF      = 4'd6,
    PH_RX_DATA      = 4'd7,
    PH_RX_TAIL      = 4'd8,
    PH_BRK_LOW_A    = 4'd9,
    PH_BRK_PAUSE    = 4'd10,
    PH_BRK_LOW_B    = 4'd11,
    PH_BRK_HIGH_END = 4'd12
  } phase_e;

  typedef struct packed {
    logic [BitTicksWidth-1:0] bit_ticks;
    logic [BrkWidth-1:0]      break_low_ticks;
    logic [BrkWidth-1:0]      break_pause_ticks;
    logic [BrkWidth-1:0]      rx_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       line_out;
    logic       line_drive;
    logic       busy;
    logic       done;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_timeout;
  } res_t;

  localparam logic [BitTicksWidth-1:0] BitTicksReset   = 16'd30;
  localparam logic [BrkWidth-1:0]      BreakLowReset   = 24'd14000;
  localparam logic [BrkWidth-1:0]      BreakPauseReset = 24'd2000;
  localparam logic [BrkWidth-1:0]      RxTimeoutReset  = 24'd40000;

endpackage

`default_nettype wire

// ----- hdl/updi_engine.sv -----
// Line timing state machine, one tick per accepted item; result is
// combinational from state registers and inputs. Depends on updi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module updi_engine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [2:0]           opcode_i,
  input  wire logic [7:0]           tx_data_i,
  input  wire logic                 line_in_i,
  input  wire updi_pkg::cfg_t       cfg_i,
  output updi_pkg::res_t            res_o
);

  localparam int unsigned CW = updi_pkg::CountWidth;

  updi_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0]    tick_q, tick_d;
  logic [3:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic             parity_q, parity_d;
  logic             drv_en_q, drv_en_d;
  logic             drv_lvl_q, drv_lvl_d;

  logic [CW-1:0] seg_dur;
  logic [CW:0]   tick_nxt;
  logic          seg_done;
  logic [CW-1:0] wait_base;
  logic [CW-1:0] wait_inc;
  logic          wait_to;
  logic          finished;
  logic          rx_fin;
  logic          rx_to;
  logic [CW-1:0] bt_ext;

  assign bt_ext   = CW'(cfg_i.bit_ticks);
  assign tick_nxt = {1'b0, tick_q} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    case (phase_q)
      updi_pkg::PH_TX_START,
      updi_pkg::PH_TX_DATA,
      updi_pkg::PH_TX_PARITY,
      updi_pkg::PH_RX_DATA:      seg_dur = bt_ext;
      updi_pkg::PH_TX_STOP:      seg_dur = bt_ext << 1;
      updi_pkg::PH_RX_HALF:      seg_dur = bt_ext >> 1;
      updi_pkg::PH_RX_TAIL:      seg_dur = bt_ext << 2;
      updi_pkg::PH_BRK_PAUSE:    seg_dur = CW'(cfg_i.break_pause_ticks);
      updi_pkg::PH_BRK_LOW_A,
      updi_pkg::PH_BRK_LOW_B,
      updi_pkg::PH_BRK_HIGH_END: seg_dur = CW'(cfg_i.break_low_ticks);
      default:                   seg_dur = '0;
    endcase
  end

  assign seg_done  = (tick_nxt >= {1'b0, seg_dur}) || tick_nxt[CW];
  assign wait_base = (phase_q == updi_pkg::PH_IDLE) ? '0 : tick_q;
  assign wait_inc  = (wait_base == updi_pkg::CntMax) ? wait_base : wait_base + CW'(1);
  assign wait_to   = (wait_inc >= CW'(cfg_i.rx_timeout_ticks)) ||
                     (wait_inc == updi_pkg::CntMax);

  // next phase and completion flags
  always_comb begin
    phase_d  = phase_q;
    finished = 1'b0;
    rx_fin   = 1'b0;
    rx_to    = 1'b0;
    case (phase_q)
      updi_pkg::PH_IDLE: begin
        case (opcode_i)
          updi_pkg::OP_SEND:   phase_d = updi_pkg::PH_TX_START;
          updi_pkg::OP_RECV: begin
            if (!line_in_i) begin
              phase_d = updi_pkg::PH_RX_HALF;
            end else if (wait_to) begin
              finished = 1'b1;
              rx_fin   = 1'b1;
              rx_to    = 1'b1;
            end else begin
              phase_d = updi_pkg::PH_RX_WAIT;
            end
          end
          updi_pkg::OP_BREAK:  phase_d = updi_pkg::PH_BRK_LOW_B;
          updi_pkg::OP_DBREAK: phase_d = updi_pkg::PH_BRK_LOW_A;
          default:             phase_d = updi_pkg::PH_IDLE;
        endcase
      end
      updi_pkg::PH_TX_START: if (seg_done) phase_d = updi_pkg::PH_TX_DATA;
      updi_pkg::PH_TX_DATA: begin
        if (seg_done && bit_q >= 4'd7) phase_d = updi_pkg::PH_TX_PARITY;
      end
      updi_pkg::PH_TX_PARITY: if (seg_done) phase_d = updi_pkg::PH_TX_STOP;
      updi_pkg::PH_TX_STOP: if (seg_done) finished = 1'b1;
      updi_pkg::PH_RX_WAIT: begin
        if (!line_in_i) begin
          phase_d = updi_pkg::PH_RX_HALF;
        end else if (wait_to) begin
          finished = 1'b1;
          rx_fin   = 1'b1;
          rx_to    = 1'b1;
        end
      end
      updi_pkg::PH_RX_HALF: if (seg_done) phase_d = updi_pkg::PH_RX_DATA;
      updi_pkg::PH_RX_DATA: begin
        if (seg_done && bit_q >= 4'd7) phase_d = updi_pkg::PH_RX_TAIL;
      end
      updi_pkg::PH_RX_TAIL: begin
        if (seg_done) begin
          finished = 1'b1;
          rx_fin   = 1'b1;
        end
      end
      updi_pkg::PH_BRK_LOW_A: if (seg_done) phase_d = updi_pkg::PH_BRK_PAUSE;
      updi_pkg::PH_BRK_PAUSE: if (seg_done) phase_d = updi_pkg::PH_BRK_LOW_B;
      updi_pkg::PH_BRK_LOW_B: if (seg_done) phase_d = updi_pkg::PH_BRK_HIGH_END;
      updi_pkg::PH_BRK_HIGH_END: if (seg_done) finished = 1'b1;
      default: phase_d = updi_pkg::PH_IDLE;
    endcase
    if (finished) phase_d = updi_pkg::PH_IDLE;
  end

  // counters, shifter and line driver
  always_comb begin
    tick_d    = tick_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    parity_d  = parity_q;
    drv_en_d  = drv_en_q;
    drv_lvl_d = drv_lvl_q;
    case (phase_q)
      updi_pkg::PH_IDLE: begin
        case (opcode_i)
          updi_pkg::OP_SEND: begin
            parity_d  = ^tx_data_i;
            shift_d   = tx_data_i;
            bit_d     = '0;
            tick_d    = '0;
            drv_en_d  = 1'b1;
            drv_lvl_d = 1'b0;
          end
          updi_pkg::OP_RECV: begin
            shift_d = '0;
            bit_d   = '0;
            tick_d  = line_in_i ? wait_inc : '0;
          end
          updi_pkg::OP_BREAK,
          updi_pkg::OP_DBREAK: begin
            tick_d    = '0;
            drv_en_d  = 1'b1;
            drv_lvl_d = 1'b0;
          end
          default: tick_d = tick_q;
        endcase
      end
      updi_pkg::PH_RX_WAIT: tick_d = line_in_i ? wait_inc : '0;
      default: begin
        tick_d = seg_done ? '0 : tick_nxt[CW-1:0];
        if (seg_done) begin
          case (phase_q)
            updi_pkg::PH_TX_START: begin
              bit_d     = '0;
              drv_lvl_d = shift_q[0];
            end
            updi_pkg::PH_TX_DATA: begin
              if (bit_q < 4'd7) begin
                bit_d     = bit_q + 4'd1;
                shift_d   = shift_q >> 1;
                drv_lvl_d = shift_q[1];
              end else begin
                drv_lvl_d = parity_q;
              end
            end
            updi_pkg::PH_TX_PARITY: drv_lvl_d = 1'b1;
            updi_pkg::PH_TX_STOP: begin
              drv_en_d  = 1'b0;
              drv_lvl_d = 1'b1;
            end
            updi_pkg::PH_RX_HALF: bit_d = '0;
            updi_pkg::PH_RX_DATA: begin
              shift_d = {line_in_i, shift_q[7:1]};
              bit_d   = bit_q + 4'd1;
            end
            updi_pkg::PH_BRK_LOW_A,
            updi_pkg::PH_BRK_LOW_B: drv_lvl_d = 1'b1;
            updi_pkg::PH_BRK_PAUSE: drv_lvl_d = 1'b0;
            updi_pkg::PH_BRK_HIGH_END: begin
              drv_en_d  = 1'b1;
              drv_lvl_d = 1'b1;
            end
            default: begin
              // unused phase codes just fall back to idle
              tick_d = tick_q;
            end
          endcase
        end
      end
    endcase
    if (finished) begin
      tick_d = '0;
      bit_d  = '0;
    end
  end

  always_comb begin
    res_o.line_out   = drv_lvl_d;
    res_o.line_drive = drv_en_d;
    res_o.busy       = (phase_d != updi_pkg::PH_IDLE);
    res_o.done       = finished;
    res_o.rx_valid   = rx_fin;
    res_o.rx_data    = (rx_fin && !rx_to) ? shift_q : 8'd0;
    res_o.rx_timeout = rx_to;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= updi_pkg::PH_IDLE;
      tick_q    <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
      parity_q  <= 1'b0;
      drv_en_q  <= 1'b0;
      drv_lvl_q <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      parity_q  <= parity_d;
      drv_en_q  <= drv_en_d;
      drv_lvl_q <= drv_lvl_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/updi_half_duplex_uart_phy.sv -----
// UPDI half-duplex UART line engine, top level: config registers, timing
// engine and a two-entry output buffer. Depends on updi_pkg, updi_engine.
// An accepted item's result is registered in the output or the skid entry.
// Throughput: one item per cycle; input stalls only when both output entries
// are full. Reset clears the engine to idle with the line released and
// the timing registers to their defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module updi_half_duplex_uart_phy (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [updi_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [updi_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [2:0]                          opcode_i,
  input  wire logic [7:0]                          tx_data_i,
  input  wire logic                                line_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     line_out_o,
  output logic                                     line_drive_o,
  output logic                                     busy_res_o,
  output logic                                     done_res_o,
  output logic                                     rx_valid_o,
  output logic [7:0]                               rx_data_o,
  output logic                                     rx_timeout_o
);

  updi_pkg::cfg_t cfg_q;
  updi_pkg::res_t res_new;
  updi_pkg::res_t out_res_q;
  updi_pkg::res_t skid_res_q;
  logic           out_valid_q;
  logic           skid_valid_q;
  logic           accept;
  logic           take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign take        = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_ticks         <= updi_pkg::BitTicksReset;
      cfg_q.break_low_ticks   <= updi_pkg::BreakLowReset;
      cfg_q.break_pause_ticks <= updi_pkg::BreakPauseReset;
      cfg_q.rx_timeout_ticks  <= updi_pkg::RxTimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        updi_pkg::CFG_BIT_TICKS:
          cfg_q.bit_ticks <= cfg_data_i[updi_pkg::BitTicksWidth-1:0];
        updi_pkg::CFG_BREAK_LOW:   cfg_q.break_low_ticks   <= cfg_data_i;
        updi_pkg::CFG_BREAK_PAUSE: cfg_q.break_pause_ticks <= cfg_data_i;
        updi_pkg::CFG_RX_TIMEOUT:  cfg_q.rx_timeout_ticks  <= cfg_data_i;
        default:                   cfg_q <= cfg_q;
      endcase
    end
  end

  updi_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .opcode_i  (opcode_i),
    .tx_data_i (tx_data_i),
    .line_in_i (line_in_i),
    .cfg_i     (cfg_q),
    .res_o     (res_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_res_q <= skid_valid_q ? skid_res_q : res_new;
    end else if (accept) begin
      skid_res_q <= res_new;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_out_o   = out_res_q.line_out;
  assign line_drive_o = out_res_q.line_drive;
  assign busy_res_o   = out_res_q.busy;
  assign done_res_o   = out_res_q.done;
  assign rx_valid_o   = out_res_q.rx_valid;
  assign rx_data_o    = out_res_q.rx_data;
  assign rx_timeout_o = out_res_q.rx_timeout;

endmodule

`default_nettype wire

// ----- tb/tb_updi_half_duplex_uart_phy.sv -----
// Testbench for updi_half_duplex_uart_phy: tick-by-tick line-engine scoreboard,
// directed commands, then random send/receive/break traffic under several timings.
// Depends on updi_pkg and updi_half_duplex_uart_phy.
`timescale 1ns / 1ps

import updi_pkg::*;

class uart_line_scoreboard;
  logic [BitTicksWidth-1:0] bit_ticks;
  logic [BrkWidth-1:0]      brk_low;
  logic [BrkWidth-1:0]      brk_pause;
  logic [BrkWidth-1:0]      rx_tout;
  phase_e                   phase;
  longint unsigned          tick_cnt;
  int unsigned              bit_idx;
  logic [7:0]               shreg;
  logic                     parity;
  logic                     drv_en;
  logic                     drv_lvl;
  res_t                     expected_levels[$];
  int                       errors;

  function new();
    bit_ticks = BitTicksReset;
    brk_low   = BreakLowReset;
    brk_pause = BreakPauseReset;
    rx_tout   = RxTimeoutReset;
    phase     = PH_IDLE;
    tick_cnt  = 0;
    bit_idx   = 0;
    shreg     = '0;
    parity    = 1'b0;
    drv_en    = 1'b0;
    drv_lvl   = 1'b1;
    errors    = 0;
  endfunction

  task flag_mismatch(string msg);
    errors++;
    if (errors <= 200) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function void write_reg(cfg_idx_e idx, logic [CfgDataWidth-1:0] value);
    case (idx)
      CFG_BIT_TICKS:   bit_ticks = value[BitTicksWidth-1:0];
      CFG_BREAK_LOW:   brk_low = value;
      CFG_BREAK_PAUSE: brk_pause = value;
      CFG_RX_TIMEOUT:  rx_tout = value;
      default: ;
    endcase
  endfunction

  function bit idle();
    return phase == PH_IDLE;
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction

  // one tick of a timed segment; 1 when the segment ends
  function bit seg_over(longint unsigned dur);
    longint unsigned nxt;
    nxt = tick_cnt + 1;
    if (nxt >= dur || nxt > CntMax) begin
      tick_cnt = 0;
      return 1'b1;
    end
    tick_cnt = nxt;
    return 1'b0;
  endfunction

  // one tick of start-bit hunt; 1 on timeout
  function bit start_hunt(logic ln);
    if (!ln) begin
      phase = PH_RX_HALF;
      tick_cnt = 0;
      return 1'b0;
    end
    if (tick_cnt < CntMax) tick_cnt++;
    return (tick_cnt >= rx_tout) || (tick_cnt >= CntMax);
  endfunction

  function void note_item(logic [2:0] op, logic [7:0] txd, logic ln);
    longint unsigned bt;
    bit fin;
    res_t r;
    bt  = bit_ticks;
    fin = 1'b0;
    r   = '0;
    if (phase == PH_IDLE) begin
      case (op)
        OP_SEND: begin
          parity   = ^txd;
          shreg    = txd;
          bit_idx  = 0;
          tick_cnt = 0;
          drv_en   = 1'b1;
          drv_lvl  = 1'b0;
          phase    = PH_TX_START;
        end
        OP_RECV: begin
          shreg    = '0;
          bit_idx  = 0;
          tick_cnt = 0;
          phase    = PH_RX_WAIT;
          if (start_hunt(ln)) begin
            fin = 1'b1;
            r.rx_valid = 1'b1;
            r.rx_timeout = 1'b1;
          end
        end
        OP_BREAK, OP_DBREAK: begin
          tick_cnt = 0;
          drv_en   = 1'b1;
          drv_lvl  = 1'b0;
          phase    = (op == OP_BREAK) ? PH_BRK_LOW_B : PH_BRK_LOW_A;
        end
        default: ;
      endcase
    end else begin
      case (phase)
        PH_TX_START: if (seg_over(bt)) begin
          phase   = PH_TX_DATA;
          bit_idx = 0;
          drv_lvl = shreg[0];
        end
        PH_TX_DATA: if (seg_over(bt)) begin
          if (bit_idx < 7) begin
            bit_idx++;
            shreg   = shreg >> 1;
            drv_lvl = shreg[0];
          end else begin
            phase   = PH_TX_PARITY;
            drv_lvl = parity;
          end
        end
        PH_TX_PARITY: if (seg_over(bt)) begin
          phase   = PH_TX_STOP;
          drv_lvl = 1'b1;
        end
        PH_TX_STOP: if (seg_over(bt * 2)) begin
          drv_en  = 1'b0;
          drv_lvl = 1'b1;
          fin     = 1'b1;
        end
        PH_RX_WAIT: if (start_hunt(ln)) begin
          fin = 1'b1;
          r.rx_valid = 1'b1;
          r.rx_timeout = 1'b1;
        end
        PH_RX_HALF: if (seg_over(bt / 2)) begin
          phase   = PH_RX_DATA;
          bit_idx = 0;
        end
        PH_RX_DATA: if (seg_over(bt)) begin
          shreg = {ln, shreg[7:1]};
          bit_idx++;
          if (bit_idx >= 8) phase = PH_RX_TAIL;
        end
        PH_RX_TAIL: if (seg_over(bt * 4)) begin
          fin = 1'b1;
          r.rx_valid = 1'b1;
          r.rx_data = shreg;
        end
        PH_BRK_LOW_A: if (seg_over(brk_low)) begin
          phase   = PH_BRK_PAUSE;
          drv_lvl = 1'b1;
        end
        PH_BRK_PAUSE: if (seg_over(brk_pause)) begin
          phase   = PH_BRK_LOW_B;
          drv_lvl = 1'b0;
        end
        PH_BRK_LOW_B: if (seg_over(brk_low)) begin
          phase   = PH_BRK_HIGH_END;
          drv_lvl = 1'b1;
        end
        PH_BRK_HIGH_END: if (seg_over(brk_low)) begin
          drv_en  = 1'b1;
          drv_lvl = 1'b1;
          fin     = 1'b1;
        end
        default: phase = PH_IDLE;
      endcase
    end
    if (fin) begin
      phase    = PH_IDLE;
      tick_cnt = 0;
      bit_idx  = 0;
      r.done   = 1'b1;
    end
    r.line_out   = drv_lvl;
    r.line_drive = drv_en;
    r.busy       = (phase != PH_IDLE);
    expected_levels.push_back(r);
  endfunction

  task cmp_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task check_result(res_t got);
    res_t want;
    if (expected_levels.size() == 0) begin
      flag_mismatch("result with no item pending");
      return;
    end
    want = expected_levels.pop_front();
    cmp_field("line_out", got.line_out, want.line_out);
    cmp_field("line_drive", got.line_drive, want.line_drive);
    cmp_field("busy", got.busy, want.busy);
    cmp_field("done", got.done, want.done);
    cmp_field("rx_valid", got.rx_valid, want.rx_valid);
    cmp_field("rx_data", got.rx_data, want.rx_data);
    cmp_field("rx_timeout", got.rx_timeout, want.rx_timeout);
  endtask
endclass

module tb_updi_half_duplex_uart_phy;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [CfgDataWidth-1:0] CfgAllOnes = {CfgDataWidth{1'b1}};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [2:0]              opcode_i;
  logic [7:0]              tx_data_i;
  logic                    line_in_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    line_out_o;
  logic                    line_drive_o;
  logic                    busy_res_o;
  logic                    done_res_o;
  logic                    rx_valid_o;
  logic [7:0]              rx_data_o;
  logic                    rx_timeout_o;

  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         items_sent;
  logic                line_plan[$];
  uart_line_scoreboard tracker;

  updi_half_duplex_uart_phy dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .tx_data_i    (tx_data_i),
    .line_in_i    (line_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_out_o   (line_out_o),
    .line_drive_o (line_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .rx_valid_o   (rx_valid_o),
    .rx_data_o    (rx_data_o),
    .rx_timeout_o (rx_timeout_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : watch
    res_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_item(opcode_i, tx_data_i, line_in_i);
      if (out_valid_o && !out_stall_i) begin
        seen.line_out   = line_out_o;
        seen.line_drive = line_drive_o;
        seen.busy       = busy_res_o;
        seen.done       = done_res_o;
        seen.rx_valid   = rx_valid_o;
        seen.rx_data    = rx_data_o;
        seen.rx_timeout = rx_timeout_o;
        tracker.check_result(seen);
      end
    end
  end

  // all driving tasks are entered and left at a falling edge
  task automatic send_item(logic [2:0] op, logic [7:0] d, logic ln);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i   = op;
    tx_data_i  = d;
    line_in_i  = ln;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic next_line(bit in_rx);
    if (line_plan.size() != 0) return line_plan.pop_front();
    return in_rx ? 1'b1 : 1'($urandom_range(1));
  endfunction

  function automatic int unsigned bit_width();
    return (tracker.bit_ticks == 0) ? 1 : tracker.bit_ticks;
  endfunction

  // high for delay ticks, then optionally a start bit and the byte LSB first
  function automatic void build_rx_plan(logic [7:0] b, int unsigned delay, bit with_start);
    int unsigned w;
    w = bit_width();
    line_plan.delete();
    repeat (delay) line_plan.push_back(1'b1);
    if (with_start) begin
      repeat (w) line_plan.push_back(1'b0);
      for (int i = 0; i < 8; i++) repeat (w) line_plan.push_back(b[i]);
    end
  endfunction

  function automatic void build_noise_plan(int unsigned len);
    line_plan.delete();
    repeat (len) line_plan.push_back(1'($urandom_range(1)));
  endfunction

  // issue a command, then keep ticking (with ignored opcodes) until the engine is idle
  task automatic run_command(logic [2:0] op, logic [7:0] d);
    bit in_rx;
    in_rx = (op == OP_RECV);
    send_item(op, d, next_line(in_rx));
    while (!tracker.idle())
      send_item(3'($urandom_range(7)), 8'($urandom_range(255)), next_line(in_rx));
    line_plan.delete();
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataWidth-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic set_timing(logic [CfgDataWidth-1:0] bt, logic [CfgDataWidth-1:0] bl,
                            logic [CfgDataWidth-1:0] bp, logic [CfgDataWidth-1:0] tout);
    settle();
    write_reg(CFG_BIT_TICKS, bt);
    write_reg(CFG_BREAK_LOW, bl);
    write_reg(CFG_BREAK_PAUSE, bp);
    write_reg(CFG_RX_TIMEOUT, tout);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random_phase(int unsigned budget, bit allow_send, bit allow_brk,
                                  bit allow_start);
    int unsigned first;
    int unsigned r;
    int unsigned tout;
    int unsigned hi;
    logic [2:0]  op;
    first = items_sent;
    while (items_sent - first < budget) begin
      line_plan.delete();
      r = $urandom_range(99);
      if (r < 30 && allow_send) op = OP_SEND;
      else if (r < 65) begin
        op   = OP_RECV;
        tout = tracker.rx_tout;
        r    = $urandom_range(99);
        if (!allow_start) build_rx_plan(8'h00, 0, 1'b0);
        else if (r < 10) build_noise_plan(12 * bit_width() + 8);
        else if (r < 22 && tout <= 64) build_rx_plan(8'($urandom_range(255)), tout, 1'b1);
        else if (r < 32 && tout <= 64) build_rx_plan(8'h00, 0, 1'b0);
        else begin
          hi = (tout == 0) ? 0 : ((tout - 1 < 12) ? tout - 1 : 12);
          build_rx_plan(8'($urandom_range(255)), $urandom_range(hi), 1'b1);
        end
      end else if (r < 75 && allow_brk) op = OP_BREAK;
      else if (r < 83 && allow_brk) op = OP_DBREAK;
      else if (r < 92) op = OP_NONE;
      else op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      run_command(op, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_BIT_TICKS;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_NONE;
    tx_data_i      = '0;
    line_in_i      = 1'b1;
    out_stall_i    = 1'b0;
    send_idle_pct  = 35;
    recv_stall_pct = 76;
    items_sent     = 0;
    tracker        = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset timing
    run_command(OP_SEND, 8'hA5);

    set_timing(2, 3, 2, 5);
    run_command(OP_SEND, 8'h00);
    run_command(OP_SEND, 8'hFF);
    run_command(OP_SEND, 8'h01);
    run_command(OP_SEND, 8'h80);
    build_rx_plan(8'hA5, 0, 1'b1);
    run_command(OP_RECV, 8'h00);
    build_rx_plan(8'h3C, 4, 1'b1);
    run_command(OP_RECV, 8'h00);
    build_rx_plan(8'h00, 0, 1'b0);
    run_command(OP_RECV, 8'h00);
    run_command(OP_BREAK, 8'h00);
    run_command(OP_DBREAK, 8'h00);
    for (logic [3:0] op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      run_command(op[2:0], 8'h5A);
    run_command(OP_NONE, 8'h00);

    set_timing(2, 1, 1, 1);
    run_random_phase(90, 1'b1, 1'b1, 1'b1);
    set_timing(0, 0, 0, 0);
    run_random_phase(90, 1'b1, 1'b1, 1'b1);
    set_timing(16'hFFFF, 2, 3, 4);
    run_random_phase(90, 1'b0, 1'b1, 1'b0);

    send_idle_pct  = 76;
    recv_stall_pct = 35;
    // upper bits of the bit-time write fall outside the register
    set_timing({8'h5A, 16'd3}, CfgAllOnes, CfgAllOnes, CfgAllOnes);
    run_random_phase(90, 1'b1, 1'b0, 1'b1);
    set_timing(1, 5, 1, 3);
    run_random_phase(90, 1'b1, 1'b1, 1'b1);
    set_timing($urandom_range(6, 2), $urandom_range(8, 1), $urandom_range(8, 1),
               $urandom_range(24, 1));
    run_random_phase(90, 1'b1, 1'b1, 1'b1);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) begin
      set_timing($urandom_range(6, 2), $urandom_range(8, 1), $urandom_range(8, 1),
                 $urandom_range(24, 1));
      run_random_phase(90, 1'b1, 1'b1, 1'b1);
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (tracker.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/updi_pkg.sv
hdl/updi_engine.sv
hdl/updi_half_duplex_uart_phy.sv
tb/tb_updi_half_duplex_uart_phy.sv
